@@ rtl/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 4;

    localparam int OPC_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int IDX_W  = 11;
    localparam int POS_W  = 11;

    localparam int IN_W    = 24;
    localparam int OUT_W   = 32;
    localparam int IN_PAD  = IN_W - OPC_W - CHAR_W - IDX_W;
    localparam int OUT_PAD = OUT_W - POS_W - CHAR_W - ATTR_W;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [OPC_W-1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_STORE,
        ST_SCROLL_PRE,
        ST_SCROLL,
        ST_CLEAR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load_item;
        logic home;
        logic cr;
        logic newline;
        logic tab_load;
        logic chr_load;
        logic store;
        logic blank_wr;
        logic blank_init;
        logic scroll_pre;
        logic scroll_step;
        logic read_cell;
        logic resp_load;
    } cmd_t;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [CHAR_W-1:0] chr;
        logic              row_last;
        logic              col_last;
        logic              cnt_zero;
        logic              cnt_one;
        logic              scan_last;
        logic              out_busy;
    } stat_t;

endpackage

`default_nettype wire

@@ rtl/tcw_ram.sv @@
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
`default_nettype none

module tcw_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_tvalid,
    output logic                in_tready,
    input  wire tcw_pkg::stat_t stat,
    output tcw_pkg::cmd_t       cmd
);

    tcw_pkg::state_t state_reg;
    tcw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcw_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_tready  = 1'b0;
        case (state_reg)
            tcw_pkg::ST_INIT:
            begin
                cmd.blank_wr   = 1'b1;
                cmd.blank_init = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                in_tready = 1'b1;
                if (in_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = tcw_pkg::ST_DISPATCH;
                end
            end
            tcw_pkg::ST_DISPATCH:
            begin
                case (tcw_pkg::op_t'(stat.opcode))
                    tcw_pkg::OP_PUT:
                    begin
                        case (stat.chr)
                            tcw_pkg::CH_NUL:
                            begin
                                state_next = tcw_pkg::ST_RESP;
                            end
                            tcw_pkg::CH_CR:
                            begin
                                cmd.cr     = 1'b1;
                                state_next = tcw_pkg::ST_RESP;
                            end
                            tcw_pkg::CH_LF:
                            begin
                                cmd.newline = 1'b1;
                                state_next  = stat.row_last ? tcw_pkg::ST_SCROLL_PRE
                                                            : tcw_pkg::ST_RESP;
                            end
                            tcw_pkg::CH_TAB:
                            begin
                                cmd.tab_load = 1'b1;
                                state_next   = tcw_pkg::ST_STORE;
                            end
                            default:
                            begin
                                cmd.chr_load = 1'b1;
                                state_next   = tcw_pkg::ST_STORE;
                            end
                        endcase
                    end
                    tcw_pkg::OP_READ:
                    begin
                        cmd.read_cell = 1'b1;
                        state_next    = tcw_pkg::ST_RESP;
                    end
                    tcw_pkg::OP_CLEAR:
                    begin
                        cmd.home   = 1'b1;
                        state_next = tcw_pkg::ST_CLEAR;
                    end
                    default:
                    begin
                        state_next = tcw_pkg::ST_RESP;
                    end
                endcase
            end
            tcw_pkg::ST_STORE:
            begin
                cmd.store = 1'b1;
                if (stat.col_last && stat.row_last)
                begin
                    state_next = tcw_pkg::ST_SCROLL_PRE;
                end
                else if (stat.cnt_one)
                begin
                    state_next = tcw_pkg::ST_RESP;
                end
            end
            tcw_pkg::ST_SCROLL_PRE:
            begin
                cmd.scroll_pre = 1'b1;
                state_next     = tcw_pkg::ST_SCROLL;
            end
            tcw_pkg::ST_SCROLL:
            begin
                cmd.scroll_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = stat.cnt_zero ? tcw_pkg::ST_RESP : tcw_pkg::ST_STORE;
                end
            end
            tcw_pkg::ST_CLEAR:
            begin
                cmd.blank_wr = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = tcw_pkg::ST_RESP;
                end
            end
            tcw_pkg::ST_RESP:
            begin
                if (!stat.out_busy)
                begin
                    cmd.resp_load = 1'b1;
                    state_next    = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/tcw_datapath.sv @@
`default_nettype none

module tcw_datapath #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [tcw_pkg::IN_W-1:0]    in_tdata,
    output logic                             out_tvalid,
    input  wire logic                        out_tready,
    output logic      [tcw_pkg::OUT_W-1:0]   out_tdata,
    input  wire logic                        cfg_we,
    input  wire logic [tcw_pkg::ATTR_W-1:0]  cfg_data,
    input  wire tcw_pkg::cmd_t               cmd,
    output tcw_pkg::stat_t                   stat
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int KEEP   = CELLS - COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CNT_W  = $clog2(TAB_STOP + 1);
    localparam int WIDE_W = ADDR_W + tcw_pkg::IDX_W;

    logic [tcw_pkg::OPC_W-1:0]  op_reg;
    logic [tcw_pkg::CHAR_W-1:0] chr_reg;
    logic [tcw_pkg::IDX_W-1:0]  idx_reg;
    logic [tcw_pkg::CHAR_W-1:0] store_chr_reg, store_chr_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [CNT_W-1:0]           mod_reg, mod_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]           row_reg, row_next;
    logic [ADDR_W-1:0]          scan_reg, scan_next;
    logic [tcw_pkg::ATTR_W-1:0] attr_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [tcw_pkg::OUT_W-1:0]  out_data_reg;

    logic                       col_last, row_last, mod_last, scan_last;
    logic [31:0]                cur_sum;
    logic [ADDR_W-1:0]          cur_lin;
    logic [WIDE_W-1:0]          idx_wide;
    logic                       in_range, resp_hit, keep_copy;

    logic                       chr_we, attr_we, ram_re;
    logic [ADDR_W-1:0]          waddr, raddr;
    logic [tcw_pkg::CHAR_W-1:0] chr_wdata, chr_rdata, resp_chr;
    logic [tcw_pkg::ATTR_W-1:0] attr_wdata, attr_rdata, resp_attr;

    assign col_last  = (col_reg == COL_W'(COLUMNS - 1));
    assign row_last  = (row_reg == ROW_W'(ROWS - 1));
    assign mod_last  = (mod_reg == CNT_W'(TAB_STOP - 1));
    assign scan_last = (scan_reg == ADDR_W'(CELLS - 1));

    assign cur_sum  = 32'(row_reg) * 32'(COLUMNS) + 32'(col_reg);
    assign cur_lin  = ADDR_W'(cur_sum);
    assign idx_wide = {{ADDR_W{1'b0}}, idx_reg};
    assign in_range = (idx_wide < WIDE_W'(CELLS));
    assign resp_hit = (op_reg == tcw_pkg::OP_READ) && in_range;

    // cursor, tab count and sweep counter
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        mod_next       = mod_reg;
        cnt_next       = cnt_reg;
        store_chr_next = store_chr_reg;
        scan_next      = scan_reg;
        if (cmd.home)
        begin
            col_next = '0;
            row_next = '0;
            mod_next = '0;
        end
        if (cmd.cr)
        begin
            col_next = '0;
            mod_next = '0;
        end
        if (cmd.newline)
        begin
            col_next = '0;
            mod_next = '0;
            if (!row_last)
            begin
                row_next = row_reg + ROW_W'(1);
            end
        end
        if (cmd.tab_load)
        begin
            store_chr_next = tcw_pkg::CH_SPACE;
            cnt_next       = CNT_W'(TAB_STOP) - mod_reg;
        end
        if (cmd.chr_load)
        begin
            store_chr_next = chr_reg;
            cnt_next       = CNT_W'(1);
        end
        if (cmd.store)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (col_last)
            begin
                col_next = '0;
                mod_next = '0;
                if (!row_last)
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
                mod_next = mod_last ? '0 : mod_reg + CNT_W'(1);
            end
        end
        if (cmd.blank_wr || cmd.scroll_step)
        begin
            scan_next = scan_last ? '0 : scan_reg + ADDR_W'(1);
        end
    end

    // screen memory ports
    always_comb
    begin
        keep_copy  = cmd.scroll_step && (32'(scan_reg) < 32'(KEEP));
        chr_we     = cmd.store || cmd.blank_wr || cmd.scroll_step;
        attr_we    = cmd.blank_wr || cmd.scroll_step;
        waddr      = cmd.store ? cur_lin : scan_reg;
        if (cmd.store)
        begin
            chr_wdata = store_chr_reg;
        end
        else if (keep_copy)
        begin
            chr_wdata = chr_rdata;
        end
        else
        begin
            chr_wdata = tcw_pkg::CH_NUL;
        end
        if (keep_copy)
        begin
            attr_wdata = attr_rdata;
        end
        else if (cmd.blank_init)
        begin
            attr_wdata = tcw_pkg::RESET_ATTR;
        end
        else
        begin
            attr_wdata = attr_reg;
        end
        ram_re = cmd.read_cell || cmd.scroll_pre
              || (cmd.scroll_step && (32'(scan_reg) + 32'd1 < 32'(KEEP)));
        if (cmd.read_cell)
        begin
            raddr = idx_wide[ADDR_W-1:0];
        end
        else if (cmd.scroll_pre)
        begin
            raddr = ADDR_W'(COLUMNS);
        end
        else
        begin
            raddr = ADDR_W'(32'(scan_reg) + 32'(COLUMNS) + 32'd1);
        end
    end

    tcw_ram #(
        .WIDTH (tcw_pkg::CHAR_W),
        .DEPTH (CELLS)
    ) u_chr_ram (
        .clk   (clk),
        .we    (chr_we),
        .waddr (waddr),
        .wdata (chr_wdata),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (chr_rdata)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::ATTR_W),
        .DEPTH (CELLS)
    ) u_attr_ram (
        .clk   (clk),
        .we    (attr_we),
        .waddr (waddr),
        .wdata (attr_wdata),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (attr_rdata)
    );

    assign resp_chr       = resp_hit ? chr_rdata : '0;
    assign resp_attr      = resp_hit ? attr_rdata : '0;
    assign out_valid_next = cmd.resp_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            mod_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            scan_reg      <= '0;
            attr_reg      <= tcw_pkg::RESET_ATTR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            mod_reg       <= mod_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        store_chr_reg <= store_chr_next;
        if (cmd.load_item)
        begin
            op_reg  <= in_tdata[tcw_pkg::OPC_W-1:0];
            chr_reg <= in_tdata[tcw_pkg::OPC_W +: tcw_pkg::CHAR_W];
            idx_reg <= in_tdata[tcw_pkg::OPC_W + tcw_pkg::CHAR_W +: tcw_pkg::IDX_W];
        end
        if (cmd.resp_load)
        begin
            out_data_reg <= {{tcw_pkg::OUT_PAD{1'b0}}, resp_attr, resp_chr,
                             tcw_pkg::POS_W'(cur_sum)};
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = out_data_reg;

    assign stat.opcode    = op_reg;
    assign stat.chr       = chr_reg;
    assign stat.row_last  = row_last;
    assign stat.col_last  = col_last;
    assign stat.cnt_zero  = (cnt_reg == '0);
    assign stat.cnt_one   = (cnt_reg == CNT_W'(1));
    assign stat.scan_last = scan_last;
    assign stat.out_busy  = out_valid_reg && !out_tready;

endmodule

`default_nettype wire

@@ rtl/text_console_writer.sv @@
// text console: a COLUMNS x ROWS screen of character and attribute bytes with a cursor
// input stream s_axis: one beat per command (put character, read cell, clear screen)
// output stream m_axis: one beat per command with the cursor position after it and,
//   for a read, the addressed cell
// cfg_we/cfg_data set the attribute used for cells blanked by clear and scroll
// a tab writes spaces up to the next tab stop; a scroll rewrites the whole screen,
//   one memory word moved per cycle; clear blanks every cell
// one command is worked at a time; the next is accepted once the result is in the output register
// the screen lives in two single-port-write rams, one for characters, one for attributes
// after reset the block sweeps every screen cell, writing char 0
//   with attribute 7, with s_axis_tready low; cfg writes are taken during the sweep
// a stalled m_axis holds its beat; the following command runs up to its result and
//   waits there, so no beat is lost or repeated
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS  = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tcw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [tcw_pkg::IN_W-1:0]    s_axis_tdata,   // opcode, char_code, cell_index
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [tcw_pkg::OUT_W-1:0]   m_axis_tdata,   // cursor_pos, cell_char, cell_attr
    input  wire logic                        cfg_we,
    input  wire logic [tcw_pkg::ATTR_W-1:0]  cfg_data
);

    tcw_pkg::cmd_t  cmd;
    tcw_pkg::stat_t stat;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_tvalid (s_axis_tvalid),
        .in_tready (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tcw_datapath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tdata   (s_axis_tdata),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_tdata  (m_axis_tdata),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule

`default_nettype wire
